/* design/bls_pkg.sv */
// Shared types, constants and helpers for the Bresenham line stepper.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bls_pkg;

  localparam int CoordBits    = 10;
  localparam int FieldBits    = 10;
  localparam int OutBits      = 11;
  localparam int OffsetBits   = 8;
  localparam int ErrBits      = CoordBits + 1;
  localparam int InDataBits   = 4 * FieldBits;
  localparam int InDataBytes  = (InDataBits + 7) / 8;
  localparam int OutDataBits  = 2 * OutBits;
  localparam int OutDataBytes = (OutDataBits + 7) / 8;
  localparam int QueueDepth   = 2;
  localparam int QueueIdxBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);
  localparam int CfgIdxBits   = 1;

  typedef enum logic [0:0] {
    KindStart   = 1'b0,
    KindAdvance = 1'b1
  } bls_kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegColumnOffset = 1'b0,
    RegRowOffset    = 1'b1
  } bls_reg_e;

  typedef logic [CoordBits-1:0] bls_coord_t;

  typedef struct packed {
    bls_kind_e  kind;
    bls_coord_t start_x;
    bls_coord_t start_y;
    bls_coord_t major_delta;
    bls_coord_t minor_delta;
    logic       major_is_x;
    logic       step_x_neg;
    logic       step_y_neg;
  } bls_cmd_t;

  function automatic bls_coord_t move_one(input bls_coord_t v, input logic negative);
    move_one = negative ? v - bls_coord_t'(1) : v + bls_coord_t'(1);
  endfunction

endpackage

`default_nettype wire

/* design/bls_front.sv */
// Front end of the line stepper: classifies each request and works out the
// deltas, octant and step directions of a new line. Depends on bls_pkg.
`default_nettype none

module bls_front (
  input  wire logic                             s_valid_i,
  input  wire logic [bls_pkg::InDataBytes*8-1:0] s_data_i,
  input  wire logic                             s_kind_i,
  output bls_pkg::bls_cmd_t                     cmd_o
);

  bls_pkg::bls_coord_t x1, y1, x2, y2, dx, dy;
  logic                major_is_x;

  always_comb begin
    x1 = bls_pkg::CoordBits'(s_data_i[0*bls_pkg::FieldBits +: bls_pkg::FieldBits]);
    y1 = bls_pkg::CoordBits'(s_data_i[1*bls_pkg::FieldBits +: bls_pkg::FieldBits]);
    x2 = bls_pkg::CoordBits'(s_data_i[2*bls_pkg::FieldBits +: bls_pkg::FieldBits]);
    y2 = bls_pkg::CoordBits'(s_data_i[3*bls_pkg::FieldBits +: bls_pkg::FieldBits]);
    dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
    major_is_x = (dx >= dy);

    cmd_o.kind        = s_kind_i ? bls_pkg::KindAdvance : bls_pkg::KindStart;
    cmd_o.start_x     = x1;
    cmd_o.start_y     = y1;
    cmd_o.major_delta = major_is_x ? dx : dy;
    cmd_o.minor_delta = major_is_x ? dy : dx;
    cmd_o.major_is_x  = major_is_x;
    cmd_o.step_x_neg  = s_valid_i & (x2 < x1);
    cmd_o.step_y_neg  = s_valid_i & (y2 < y1);
  end

endmodule

`default_nettype wire

/* design/bls_queue.sv */
// Short command queue between the front end and the stepping back end.
// Depends on bls_pkg for the command type and the queue depth.
`default_nettype none

module bls_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bls_pkg::bls_cmd_t push_cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output bls_pkg::bls_cmd_t      pop_cmd_o
);

  bls_pkg::bls_cmd_t                  mem_q [bls_pkg::QueueDepth];
  logic [bls_pkg::QueueIdxBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bls_pkg::QueueCntBits-1:0]   count_q, count_d;
  logic                               do_push, do_pop;

  assign full_o    = (count_q == bls_pkg::QueueCntBits'(bls_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == bls_pkg::QueueIdxBits'(bls_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == bls_pkg::QueueIdxBits'(bls_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* design/bls_back.sv */
// Back end of the line stepper: holds the cursor and error state, steps one
// pixel per command and registers the result. Depends on bls_pkg.
`default_nettype none

module bls_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cmd_valid_i,
  input  wire bls_pkg::bls_cmd_t                 cmd_i,
  output logic                                   cmd_pop_o,
  input  wire logic [bls_pkg::OffsetBits-1:0]    column_offset_i,
  input  wire logic [bls_pkg::OffsetBits-1:0]    row_offset_i,
  output logic                                   line_active_o,
  output logic                                   m_valid_o,
  input  wire logic                              m_ready_i,
  output logic                                   m_pixel_valid_o,
  output logic [bls_pkg::OutBits-1:0]            m_pixel_x_o,
  output logic [bls_pkg::OutBits-1:0]            m_pixel_y_o,
  output logic                                   m_last_o
);

  bls_pkg::bls_coord_t          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  bls_pkg::bls_coord_t          major_q, major_d, minor_q, minor_d, left_q, left_d;
  logic [bls_pkg::ErrBits-1:0]  err_q, err_d;
  logic                         major_is_x_q, major_is_x_d;
  logic                         step_x_neg_q, step_x_neg_d, step_y_neg_q, step_y_neg_d;
  logic                         active_q, active_d;
  logic                         out_valid_q;

  bls_pkg::bls_coord_t          eff_x, eff_y, eff_major, eff_minor, eff_left;
  logic [bls_pkg::ErrBits-1:0]  eff_err, err_add;
  logic                         eff_major_is_x, eff_step_x_neg, eff_step_y_neg, eff_active;
  logic                         last, minor_step;
  logic                         res_valid, res_last;
  logic [bls_pkg::OutBits-1:0]  res_x, res_y;

  assign cmd_pop_o     = cmd_valid_i & (~out_valid_q | m_ready_i);
  assign line_active_o = active_q;
  assign m_valid_o     = out_valid_q;

  always_comb begin
    eff_x          = cur_x_q;
    eff_y          = cur_y_q;
    eff_major      = major_q;
    eff_minor      = minor_q;
    eff_left       = left_q;
    eff_err        = err_q;
    eff_major_is_x = major_is_x_q;
    eff_step_x_neg = step_x_neg_q;
    eff_step_y_neg = step_y_neg_q;
    eff_active     = active_q;
    if (cmd_i.kind == bls_pkg::KindStart) begin
      eff_x          = cmd_i.start_x;
      eff_y          = cmd_i.start_y;
      eff_major      = cmd_i.major_delta;
      eff_minor      = cmd_i.minor_delta;
      eff_left       = cmd_i.major_delta;
      eff_err        = bls_pkg::ErrBits'(cmd_i.major_delta) >> 1;
      eff_major_is_x = cmd_i.major_is_x;
      eff_step_x_neg = cmd_i.step_x_neg;
      eff_step_y_neg = cmd_i.step_y_neg;
      eff_active     = 1'b1;
    end

    last       = (eff_left == '0);
    err_add    = eff_err + bls_pkg::ErrBits'(eff_minor);
    minor_step = (err_add >= bls_pkg::ErrBits'(eff_major));

    res_valid = eff_active;
    res_last  = eff_active & last;
    res_x     = eff_active ? bls_pkg::OutBits'(eff_x) + bls_pkg::OutBits'(column_offset_i)
                           : '0;
    res_y     = eff_active ? bls_pkg::OutBits'(eff_y) + bls_pkg::OutBits'(row_offset_i)
                           : '0;

    cur_x_d      = eff_x;
    cur_y_d      = eff_y;
    major_d      = eff_major;
    minor_d      = eff_minor;
    left_d       = eff_left;
    err_d        = eff_err;
    major_is_x_d = eff_major_is_x;
    step_x_neg_d = eff_step_x_neg;
    step_y_neg_d = eff_step_y_neg;
    active_d     = eff_active & ~last;
    if (eff_active && !last) begin
      left_d = eff_left - 1'b1;
      err_d  = minor_step ? err_add - bls_pkg::ErrBits'(eff_major) : err_add;
      if (eff_major_is_x) begin
        cur_x_d = bls_pkg::move_one(eff_x, eff_step_x_neg);
        if (minor_step) begin
          cur_y_d = bls_pkg::move_one(eff_y, eff_step_y_neg);
        end
      end else begin
        cur_y_d = bls_pkg::move_one(eff_y, eff_step_y_neg);
        if (minor_step) begin
          cur_x_d = bls_pkg::move_one(eff_x, eff_step_x_neg);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      major_q      <= '0;
      minor_q      <= '0;
      left_q       <= '0;
      err_q        <= '0;
      major_is_x_q <= 1'b0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        cur_x_q      <= cur_x_d;
        cur_y_q      <= cur_y_d;
        major_q      <= major_d;
        minor_q      <= minor_d;
        left_q       <= left_d;
        err_q        <= err_d;
        major_is_x_q <= major_is_x_d;
        step_x_neg_q <= step_x_neg_d;
        step_y_neg_q <= step_y_neg_d;
        active_q     <= active_d;
        out_valid_q  <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      m_pixel_valid_o <= res_valid;
      m_pixel_x_o     <= res_x;
      m_pixel_y_o     <= res_y;
      m_last_o        <= res_last;
    end
  end

endmodule

`default_nettype wire

/* design/bresenham_line_stepper.sv */
// Top level of the Bresenham line stepper: stream ports, offset registers,
// and the front end, command queue and back end. Depends on bls_pkg.
//
// A start request (tuser 0) loads two endpoints and returns the first pixel;
// each advance request (tuser 1) returns the next pixel of the line, and the
// second endpoint comes back with tlast set, after which the line is idle. An
// advance with no line in progress returns a result with tuser 0 and zero data.
// Unless a side stalls, one request is taken and one result given per clock
// cycle: the back end steps the cursor and error term once per cycle. A
// two-entry queue between front and back end and the output register let
// either side stall. The user must write offsets through the configuration
// channel only while the block is idle; the block itself does not enforce this.
`default_nettype none

module bresenham_line_stepper (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [bls_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  wire logic [bls_pkg::OffsetBits-1:0]        cfg_data_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [bls_pkg::InDataBytes*8-1:0]     s_axis_tdata,
  // kind
  input  wire logic [0:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // pixel_x, pixel_y, zero padding
  output logic [bls_pkg::OutDataBytes*8-1:0]         m_axis_tdata,
  // pixel_valid
  output logic [0:0]                                 m_axis_tuser,
  output logic                                       m_axis_tlast
);

  logic [bls_pkg::OffsetBits-1:0] column_offset_q, row_offset_q;
  bls_pkg::bls_cmd_t              front_cmd, queue_cmd;
  logic                           queue_full, queue_empty, back_pop, line_active;
  logic                           pixel_valid;
  logic [bls_pkg::OutBits-1:0]    pixel_x, pixel_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_offset_q <= '0;
      row_offset_q    <= '0;
    end else if (cfg_valid_i) begin
      case (bls_pkg::bls_reg_e'(cfg_index_i))
        bls_pkg::RegColumnOffset: column_offset_q <= cfg_data_i;
        bls_pkg::RegRowOffset:    row_offset_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bls_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_kind_i  (s_axis_tuser[0]),
    .cmd_o     (front_cmd)
  );

  assign s_axis_tready = ~queue_full;

  bls_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (back_pop),
    .empty_o    (queue_empty),
    .pop_cmd_o  (queue_cmd)
  );

  bls_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (~queue_empty),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (back_pop),
    .column_offset_i (column_offset_q),
    .row_offset_i    (row_offset_q),
    .line_active_o   (line_active),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_pixel_valid_o (pixel_valid),
    .m_pixel_x_o     (pixel_x),
    .m_pixel_y_o     (pixel_y),
    .m_last_o        (m_axis_tlast)
  );

  assign m_axis_tuser = pixel_valid;
  assign m_axis_tdata = {{(bls_pkg::OutDataBytes*8 - bls_pkg::OutDataBits){1'b0}},
                         pixel_y, pixel_x};

  // A line can only finish by handing a flagged pixel to the output register.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(line_active) |-> (m_axis_tvalid && m_axis_tlast && m_axis_tuser[0]))
    else $error("line went idle without a last pixel");

  // An advance with no line gives a blank result.
  a_blank_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("result without a pixel carries data");

  // The back end only takes a command when the queue holds one and the output register has room.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> (!queue_empty && (!m_axis_tvalid || m_axis_tready)))
    else $error("command taken with no room for its result");

endmodule

`default_nettype wire

/* tb/bls_pixel_checker.sv */
// Pixel checker for the Bresenham line stepper: watches the configuration,
// request and result channels, predicts each pixel and compares it field by field.
// Depends on bls_pkg for the coordinate types, request kinds and register indexes.
module bls_pixel_checker
  import bls_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [CfgIdxBits-1:0]         cfg_index_i,
  input  wire logic [OffsetBits-1:0]         cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  // start_x, start_y, end_x, end_y
  input  wire logic [InDataBytes*8-1:0]      in_data_i,
  // kind
  input  wire logic [0:0]                    in_user_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  // pixel_x, pixel_y, zero padding
  input  wire logic [OutDataBytes*8-1:0]     out_data_i,
  // pixel_valid
  input  wire logic [0:0]                    out_user_i,
  input  wire logic                          out_last_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               valid;
    logic [OutBits-1:0] x;
    logic [OutBits-1:0] y;
    logic               last;
  } pixel_t;

  logic [OffsetBits-1:0] col_off;
  logic [OffsetBits-1:0] row_off;
  bls_coord_t            cur_x;
  bls_coord_t            cur_y;
  bls_coord_t            major_d;
  bls_coord_t            minor_d;
  bls_coord_t            remaining;
  logic [ErrBits-1:0]    err_acc;
  logic                  x_major;
  logic                  neg_x;
  logic                  neg_y;
  logic                  active;
  pixel_t                pending_pixels[$];
  int                    mismatches;

  assign fail_count_o = mismatches;

  function automatic bls_coord_t step_coord(bls_coord_t v, logic negative);
    return negative ? v - bls_coord_t'(1) : v + bls_coord_t'(1);
  endfunction

  function automatic pixel_t plot_pixel();
    pixel_t             p;
    logic [ErrBits-1:0] acc;
    p.valid = 1'b1;
    p.x     = OutBits'(cur_x) + OutBits'(col_off);
    p.y     = OutBits'(cur_y) + OutBits'(row_off);
    p.last  = (remaining == '0);
    if (p.last) begin
      active = 1'b0;
    end else begin
      remaining = remaining - bls_coord_t'(1);
      acc = err_acc + ErrBits'(minor_d);
      if (acc >= ErrBits'(major_d)) begin
        acc = acc - ErrBits'(major_d);
        if (x_major) cur_y = step_coord(cur_y, neg_y);
        else cur_x = step_coord(cur_x, neg_x);
      end
      err_acc = acc;
      if (x_major) cur_x = step_coord(cur_x, neg_x);
      else cur_y = step_coord(cur_y, neg_y);
    end
    return p;
  endfunction

  function automatic pixel_t predict_pixel(bls_kind_e kind,
                                           logic [InDataBytes*8-1:0] data);
    bls_coord_t x0;
    bls_coord_t y0;
    bls_coord_t x1;
    bls_coord_t y1;
    bls_coord_t dx;
    bls_coord_t dy;
    pixel_t     p;
    p = '0;
    if (kind == KindStart) begin
      x0        = data[0*FieldBits +: CoordBits];
      y0        = data[1*FieldBits +: CoordBits];
      x1        = data[2*FieldBits +: CoordBits];
      y1        = data[3*FieldBits +: CoordBits];
      dx        = (x1 >= x0) ? x1 - x0 : x0 - x1;
      dy        = (y1 >= y0) ? y1 - y0 : y0 - y1;
      neg_x     = (x1 < x0);
      neg_y     = (y1 < y0);
      x_major   = (dx >= dy);
      major_d   = x_major ? dx : dy;
      minor_d   = x_major ? dy : dx;
      err_acc   = ErrBits'(major_d >> 1);
      remaining = major_d;
      cur_x     = x0;
      cur_y     = y0;
      active    = 1'b1;
      p = plot_pixel();
    end else if (active) begin
      p = plot_pixel();
    end
    return p;
  endfunction

  function automatic int check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      col_off    = '0;
      row_off    = '0;
      cur_x      = '0;
      cur_y      = '0;
      major_d    = '0;
      minor_d    = '0;
      remaining  = '0;
      err_acc    = '0;
      x_major    = 1'b0;
      neg_x      = 1'b0;
      neg_y      = 1'b0;
      active     = 1'b0;
      mismatches = 0;
      pending_pixels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (bls_reg_e'(cfg_index_i))
          RegColumnOffset: col_off = cfg_data_i;
          RegRowOffset:    row_off = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.valid = out_user_i[0];
        got.x     = out_data_i[0 +: OutBits];
        got.y     = out_data_i[OutBits +: OutBits];
        got.last  = out_last_i;
        if (pending_pixels.size() == 0) begin
          $error("unexpected result: pixel_valid %0d, pixel_x %0d, pixel_y %0d",
                 got.valid, got.x, got.y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          mismatches += check_field("pixel_valid", want.valid, got.valid);
          mismatches += check_field("pixel_x", want.x, got.x);
          mismatches += check_field("pixel_y", want.y, got.y);
          mismatches += check_field("last_pixel", want.last, got.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_pixels.push_back(predict_pixel(bls_kind_e'(in_user_i[0]), in_data_i));
      end
      pending_o <= pending_pixels.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the Bresenham line stepper: clock, reset, request and
// offset stimulus, randomly stalling result sink and the final verdict.
// Depends on bls_pkg, bresenham_line_stepper and bls_pixel_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bls_pkg::*;

  localparam int TotalItems = 1850;
  localparam int HoldCycles = 120;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [CfgIdxBits-1:0]         cfg_index_i   = '0;
  logic [OffsetBits-1:0]         cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [InDataBytes*8-1:0]      s_axis_tdata  = '0;
  logic [0:0]                    s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OutDataBytes*8-1:0]     m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int hold_trigger = 0;
  int items_sent   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bresenham_line_stepper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  bls_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic int line_span(bls_coord_t sx, bls_coord_t sy,
                                   bls_coord_t ex, bls_coord_t ey);
    int dx;
    int dy;
    dx = (ex >= sx) ? ex - sx : sx - ex;
    dy = (ey >= sy) ? ey - sy : sy - ey;
    return (dx >= dy) ? dx : dy;
  endfunction

  function automatic bls_coord_t near_coord(bls_coord_t c, int d);
    int lo;
    int hi;
    lo = (int'(c) - d < 0) ? 0 : int'(c) - d;
    hi = (int'(c) + d > 1023) ? 1023 : int'(c) + d;
    return bls_coord_t'($urandom_range(hi, lo));
  endfunction

  task automatic send_req(bls_kind_e kind, bls_coord_t sx, bls_coord_t sy,
                          bls_coord_t ex, bls_coord_t ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ey, ex, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_advance();
    send_req(KindAdvance, bls_coord_t'($urandom), bls_coord_t'($urandom),
             bls_coord_t'($urandom), bls_coord_t'($urandom));
  endtask

  task automatic run_line(bls_coord_t sx, bls_coord_t sy, bls_coord_t ex,
                          bls_coord_t ey, int advances);
    send_req(KindStart, sx, sy, ex, ey);
    repeat (advances) send_advance();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_offsets(logic [OffsetBits-1:0] col, logic [OffsetBits-1:0] row);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegColumnOffset;
    cfg_data_i  <= col;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= RegRowOffset;
    cfg_data_i  <= row;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_end;
    int         pick;
    int         span;
    int         advances;
    int         reach;
    bls_coord_t sx;
    bls_coord_t sy;
    bls_coord_t ex;
    bls_coord_t ey;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_offsets('0, '0);
    send_req(KindAdvance, '1, '1, '1, '1);
    run_line(0, 0, 0, 0, 1);
    run_line(0, 1023, 1023, 0, 2);
    run_line(2, 5, 7, 3, 5);
    run_line(10, 10, 8, 14, 4);
    wait_drained();
    write_offsets('1, '1);
    run_line(1023, 1023, 1023, 1023, 0);
    run_line(1020, 1022, 1023, 1019, 3);

    phase = 0;
    while (items_sent < TotalItems) begin
      wait_drained();
      if (phase % 3 == 0) begin
        write_offsets($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
      end else begin
        write_offsets(OffsetBits'($urandom), OffsetBits'($urandom));
      end
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 45;
      endcase
      if (phase == 1) begin
        idle_pct = 0;
        hold_trigger++;
      end
      phase_end = items_sent + 250;
      while (items_sent < phase_end && items_sent < TotalItems) begin
        pick = $urandom_range(99);
        sx = bls_coord_t'($urandom);
        sy = bls_coord_t'($urandom);
        if ($urandom_range(19) == 0) begin
          ex = bls_coord_t'($urandom);
          ey = bls_coord_t'($urandom);
        end else begin
          reach = $urandom_range(12);
          ex = near_coord(sx, reach);
          ey = near_coord(sy, reach);
        end
        span = line_span(sx, sy, ex, ey);
        if (pick < 75) begin
          advances = span;
          if ($urandom_range(9) == 0) advances += $urandom_range(2, 1);
        end else if (pick < 90) begin
          advances = (span == 0) ? 0 : $urandom_range(span - 1);
        end else begin
          advances = -1;
        end
        if (advances > 120) advances = $urandom_range(120, 40);
        if (advances < 0) begin
          send_req(bls_kind_e'($urandom_range(1)), sx, sy, ex, ey);
        end else begin
          run_line(sx, sy, ex, ey, advances);
        end
      end
      phase++;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int gap_left;
    int hold_left;
    int hold_seen;
    gap_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else begin
        gap_left = pick_gap();
        if (gap_left > 0) begin
          gap_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* bresenham_line_stepper.f */
design/bls_pkg.sv
design/bls_front.sv
design/bls_queue.sv
design/bls_back.sv
design/bresenham_line_stepper.sv
tb/bls_pixel_checker.sv
tb/tb.sv
